// ===== rtl/qfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// qfsp_pkg: shared types and constants for the quadratic-fit smoother
// Holds the tap count, Q2.16 coefficient rows, the controller command
// struct and the Q16.16 output saturation.
// ----------------------------------------------------------------------------
package qfsp_pkg;

	localparam int TAPS   = 10;
	localparam int TAP_W  = 4;   // index bits for TAPS entries
	localparam int COEF_W = 18;  // Q2.16 signed
	localparam int RES_W  = 32;  // Q16.16 result

	typedef logic [TAP_W-1:0]         tap_idx_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [RES_W-1:0]  res_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     load;      // store a new sample, clear accumulators
		logic     issue;     // multiply one tap
		tap_idx_t tap;       // tap number, 0 = newest sample
		logic     load_out;  // latch saturated sums into output register
	} qfsp_cmd_t;

	// Fitted value at the newest sample, newest tap first
	function automatic coef_t coef_now(input tap_idx_t k);
		coef_t c;
		unique case (k)
			4'd0:    c = 18'sd40513;
			4'd1:    c = 18'sd25023;
			4'd2:    c = 18'sd12511;
			4'd3:    c = 18'sd2979;
			4'd4:    c = -18'sd3575;
			4'd5:    c = -18'sd7149;
			4'd6:    c = -18'sd7745;
			4'd7:    c = -18'sd5362;
			4'd8:    c = 18'sd0;
			4'd9:    c = 18'sd8341;
			default: c = 18'sd0;
		endcase
		return c;
	endfunction

	// One-step-ahead extrapolation row
	function automatic coef_t coef_ahead(input tap_idx_t k);
		coef_t c;
		unique case (k)
			4'd0:    c = 18'sd58982;
			4'd1:    c = 18'sd32768;
			4'd2:    c = 18'sd12015;
			4'd3:    c = -18'sd3277;
			4'd4:    c = -18'sd13107;
			4'd5:    c = -18'sd17476;
			4'd6:    c = -18'sd16384;
			4'd7:    c = -18'sd9830;
			4'd8:    c = 18'sd2185;
			4'd9:    c = 18'sd19661;
			default: c = 18'sd0;
		endcase
		return c;
	endfunction

	// Clamp a wide sum to signed 32 bits
	function automatic res_t sat_res(input logic signed [63:0] v);
		res_t r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[RES_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/qfsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// qfsp_ctrl: sequencer for the quadratic-fit smoother
// Accepts a sample, steps the shared multiply-accumulate over all taps,
// then hands the result to the output register and tracks its valid flag.
// ----------------------------------------------------------------------------
module qfsp_ctrl
	import qfsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output qfsp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_FLUSH,
		ST_RESULT
	} state_t;

	state_t   state_q;
	tap_idx_t tap_q;
	logic     out_valid_q;
	logic     load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign load_out  = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	// Commands
	always_comb begin
		cmd.load     = in_valid && in_ready;
		cmd.issue    = (state_q == ST_MAC);
		cmd.tap      = tap_q;
		cmd.load_out = load_out;
	end

	// State, tap counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					tap_q <= '0;
					if (in_valid) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (tap_q == tap_idx_t'(TAPS - 1)) begin
						state_q <= ST_FLUSH;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/qfsp_datapath.sv =====
// ----------------------------------------------------------------------------
// qfsp_datapath: sample ring, shared multipliers and accumulators
// One tap per cycle is read from the ring, multiplied by both coefficient
// rows, registered, then added into two accumulators.
// ----------------------------------------------------------------------------
module qfsp_datapath
	import qfsp_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  qfsp_cmd_t                      cmd,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output res_t                           current_estimate,
	output res_t                           predicted_next
);

	localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
	// coefficient magnitudes sum below 2^18 per row
	localparam int ACC_W  = SAMPLE_WIDTH + 20;

	logic signed [SAMPLE_WIDTH-1:0] ring_q [TAPS];
	tap_idx_t                       wp_q;
	tap_idx_t                       wp_next;
	tap_idx_t                       rd_idx_q;
	logic signed [SAMPLE_WIDTH-1:0] x_rd;
	logic signed [PROD_W-1:0]       prod_now_s1;
	logic signed [PROD_W-1:0]       prod_ahead_s1;
	logic                           prod_vld_s1;
	logic signed [ACC_W-1:0]        acc_now_q;
	logic signed [ACC_W-1:0]        acc_ahead_q;
	res_t                           cur_q;
	res_t                           pred_q;

	assign wp_next = (wp_q == tap_idx_t'(TAPS - 1)) ? '0 : wp_q + 1'b1;
	assign x_rd    = ring_q[rd_idx_q];

	// Ring write and read pointer, walking newest to oldest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				ring_q[i] <= '0;
			end
			wp_q     <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.load) begin
				ring_q[wp_next] <= sample;
				wp_q            <= wp_next;
				rd_idx_q        <= wp_next;
			end else if (cmd.issue) begin
				rd_idx_q <= (rd_idx_q == '0) ? tap_idx_t'(TAPS - 1) : rd_idx_q - 1'b1;
			end
		end
	end

	// Product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_now_s1   <= PROD_W'(x_rd) * PROD_W'(coef_now(cmd.tap));
		prod_ahead_s1 <= PROD_W'(x_rd) * PROD_W'(coef_ahead(cmd.tap));
	end

	// Accumulate and output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_now_q   <= '0;
			acc_ahead_q <= '0;
		end else if (prod_vld_s1) begin
			acc_now_q   <= acc_now_q + ACC_W'(prod_now_s1);
			acc_ahead_q <= acc_ahead_q + ACC_W'(prod_ahead_s1);
		end
		if (cmd.load_out) begin
			cur_q  <= sat_res(64'(acc_now_q));
			pred_q <= sat_res(64'(acc_ahead_q));
		end
	end

	assign current_estimate = cur_q;
	assign predicted_next   = pred_q;

endmodule

// ===== rtl/quadratic_fit_smoother_predictor.sv =====
// ----------------------------------------------------------------------------
// quadratic_fit_smoother_predictor: 10-tap quadratic-fit smoother/predictor
// Keeps the last ten samples and gives the least-squares quadratic value at
// the newest sample and one step ahead, both Q16.16 and saturated.
//
// Channel  Handshake            Beat contents
// in       in_valid/in_ready    sample (SAMPLE_WIDTH bits, signed)
// out      out_valid/out_ready  current_estimate, predicted_next (32b signed)
//
// Each item is accepted, then swept through the shared pair of multipliers
// over all ten taps (one tap per cycle), then the product register drains
// and the output register loads.
// The output register lets the next sample be accepted while a result waits.
// Reset clears the sample ring and write position at once; no clearing pass.
// A stalled output holds the block in its result state until the beat is taken.
// ----------------------------------------------------------------------------
module quadratic_fit_smoother_predictor
	import qfsp_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output res_t                           current_estimate,
	output res_t                           predicted_next
);

	qfsp_cmd_t cmd;

	qfsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	qfsp_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sample           (sample),
		.current_estimate (current_estimate),
		.predicted_next   (predicted_next)
	);

endmodule

// ===== rtl/qfsp_checker.sv =====
// ----------------------------------------------------------------------------
// qfsp_checker: port-level checks for the quadratic-fit smoother
// Watches the handshakes and the busy window after each accepted beat.
// ----------------------------------------------------------------------------
module qfsp_checker
	import qfsp_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic signed [SAMPLE_WIDTH-1:0] sample,
	input logic                           out_valid,
	input logic                           out_ready,
	input res_t                           current_estimate,
	input res_t                           predicted_next
);

	// Waiting sample beat holds valid and payload until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample))
		else $error("sample beat changed or dropped before it was taken");

	// Result beat holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before beat was taken");

	// Stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(current_estimate) && $stable(predicted_next))
		else $error("result payload changed while stalled");

	// Busy right after an accepted sample
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after accepting a sample");

	// Still busy at the end of the tap sweep
	a_busy_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##12 !in_ready)
		else $error("in_ready returned before the tap sweep finished");

endmodule

bind quadratic_fit_smoother_predictor qfsp_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_qfsp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.sample           (sample),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.current_estimate (current_estimate),
	.predicted_next   (predicted_next)
);

// ===== tb/sv/tb_quadratic_fit_smoother_predictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_fit_smoother_predictor: self-checking bench for the 10-tap
// quadratic-fit smoother/predictor
// Streams signed samples through the block with random handshake gaps on
// both sides. A local model keeps its own sample history and computes both
// Q16.16 fit outputs per sample. Each output beat is checked in order.
// ----------------------------------------------------------------------------
module tb_quadratic_fit_smoother_predictor;
	import qfsp_pkg::*;

	localparam int SW          = 16;
	localparam int HIST_DEPTH  = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BEATS = 1500;

	typedef logic signed [SW-1:0] smp_t;

	typedef struct {
		res_t cur;
		res_t nxt;
	} fit_beat_t;

	// Q2.16 weights, newest sample first
	localparam int SMOOTH_W [HIST_DEPTH] = '{
		40513, 25023, 12511, 2979, -3575, -7149, -7745, -5362, 0, 8341
	};
	localparam int AHEAD_W [HIST_DEPTH] = '{
		58982, 32768, 12015, -3277, -13107, -17476, -16384, -9830, 2185, 19661
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	smp_t sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	res_t current_estimate;
	res_t predicted_next;

	quadratic_fit_smoother_predictor #(
		.SAMPLE_WIDTH(SW)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sample           (sample),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.current_estimate (current_estimate),
		.predicted_next   (predicted_next)
	);

	always #5 clk = ~clk;

	smp_t      pending_samples[$];
	fit_beat_t fit_expect[$];
	smp_t      hist[HIST_DEPTH];
	int        hist_pos;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        err_count;
	int        cycle_count;
	logic      in_taken;

	// Clamp a wide sum to signed 32 bits
	function automatic res_t clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return res_t'(v);
	endfunction

	// Store a sample in the history and compute both fit outputs
	function automatic fit_beat_t advance_fit(input smp_t s);
		fit_beat_t r;
		longint acc_s;
		longint acc_a;
		longint x;
		int idx;
		acc_s = 0;
		acc_a = 0;
		hist_pos = (hist_pos >= HIST_DEPTH - 1) ? 0 : hist_pos + 1;
		hist[hist_pos] = s;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			idx = (hist_pos + HIST_DEPTH - k) % HIST_DEPTH;
			x = longint'(hist[idx]);
			acc_s += x * longint'(SMOOTH_W[k]);
			acc_a += x * longint'(AHEAD_W[k]);
		end
		r.cur = clamp32(acc_s);
		r.nxt = clamp32(acc_a);
		return r;
	endfunction

	// Ten full-scale samples whose signs follow the smoothing weights, so the
	// sums run past 32 bits; polarity flips the whole run
	task automatic queue_overload_run(input bit negative);
		smp_t v;
		for (int k = HIST_DEPTH - 1; k >= 0; k--) begin
			v = ((SMOOTH_W[k] >= 0) ^ negative) ? smp_t'(32767) : smp_t'(-32768);
			pending_samples.push_back(v);
		end
	endtask

	task automatic queue_random_beats(input int n);
		int pick;
		int sent;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				pending_samples.push_back(smp_t'($urandom_range(0, 65535)));
				sent++;
			end else if (pick < 75) begin
				pending_samples.push_back(smp_t'($urandom_range(0, 200) - 100));
				sent++;
			end else if (pick < 85) begin
				pending_samples.push_back($urandom_range(0, 1) ? smp_t'(32767) : smp_t'(-32768));
				sent++;
			end else begin
				queue_overload_run($urandom_range(0, 1));
				sent += HIST_DEPTH;
			end
		end
	endtask

	task automatic drain_pending();
		while (pending_samples.size() != 0)
			@(negedge clk);
	endtask

	// Sender: present the next queued sample at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				sample   <= pending_samples.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random backpressure
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Monitor: predict on accepted samples, check accepted results
	always @(posedge clk) begin
		fit_beat_t want;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycle_count);
			$display("== FAIL ==");
			$finish;
		end
		if (!arst_n) begin
			in_taken <= 1'b0;
			hist_pos = 0;
			for (int i = 0; i < HIST_DEPTH; i++)
				hist[i] = '0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (fit_expect.size() == 0) begin
					$display("%0t unexpected result beat: cur %0d next %0d",
						$time, current_estimate, predicted_next);
					err_count++;
				end else begin
					want = fit_expect.pop_front();
					if (current_estimate !== want.cur) begin
						$display("%0t current_estimate mismatch: expected %0d actual %0d",
							$time, want.cur, current_estimate);
						err_count++;
					end
					if (predicted_next !== want.nxt) begin
						$display("%0t predicted_next mismatch: expected %0d actual %0d",
							$time, want.nxt, predicted_next);
						err_count++;
					end
				end
			end
			if (in_valid && in_ready)
				fit_expect.push_back(advance_fit(sample));
		end
	end

	// Stimulus and phase control
	initial begin
		err_count     = 0;
		cycle_count   = 0;
		send_idle_pct = 14;
		recv_idle_pct = 59;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: partly filled history, then full-scale overload both ways
		pending_samples.push_back(smp_t'(32767));
		pending_samples.push_back(smp_t'(-32768));
		pending_samples.push_back(smp_t'(0));
		queue_overload_run(1'b0);
		queue_overload_run(1'b1);
		queue_random_beats(RANDOM_BEATS / 3);
		drain_pending();

		@(posedge clk);
		send_idle_pct = 59;
		recv_idle_pct = 14;
		queue_random_beats(RANDOM_BEATS / 3);
		drain_pending();

		@(posedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_beats(RANDOM_BEATS / 3);

		// Wait for every result, then keep watching for stray beats
		while (pending_samples.size() != 0 || in_valid || fit_expect.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (err_count == 0 && fit_expect.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
